/* design/mpsd_pkg.sv */
// Shared types, constants and the Morse character ROM for the pair stream decoder.
`timescale 1ns / 1ps
`default_nettype none

package mpsd_pkg;

    localparam int MAX_SYMBOLS   = 7;
    localparam int CODE_W        = 14;
    localparam int CHAR_W        = 7;
    localparam int BYTE_W        = 8;
    localparam int SYMS_PER_BYTE = 4;
    localparam int COUNT_W       = $clog2(MAX_SYMBOLS + 1);
    localparam int FIFO_DEPTH    = 2;
    localparam int FIFO_PTR_W    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W    = $clog2(FIFO_DEPTH + 1);

    localparam logic [CHAR_W-1:0] SPACE_CHAR = 7'h20;
    localparam logic [CODE_W-1:0] SPACE_CODE = 14'd3;

    // 2-bit symbol codes
    typedef enum logic [1:0] {
        SYM_SEP   = 2'd0,
        SYM_DASH  = 2'd1,
        SYM_DOT   = 2'd2,
        SYM_SPACE = 2'd3
    } sym_t;

    // What one symbol slot of a byte produces
    typedef enum logic [1:0] {
        EV_NONE,
        EV_SPACE,
        EV_CHAR
    } ev_kind_t;

    typedef struct packed {
        ev_kind_t            kind;
        logic                ovf;
        logic [CODE_W-1:0]   code;
    } event_t;

    // Slot 0 holds the event of bits 7:6
    typedef struct packed {
        event_t [SYMS_PER_BYTE-1:0] ev;
    } group_t;

    typedef struct packed {
        logic                found;
        logic [CHAR_W-1:0]   ch;
    } rom_result_t;

    // Morse ROM: code -> ASCII
    function automatic rom_result_t rom_lookup(input logic [CODE_W-1:0] code);
        rom_result_t r;
        r.found = 1'b1;
        r.ch    = '0;
        unique case (code)
            14'd9:     r.ch = 7'h41;
            14'd106:   r.ch = 7'h42;
            14'd102:   r.ch = 7'h43;
            14'd26:    r.ch = 7'h44;
            14'd2:     r.ch = 7'h45;
            14'd166:   r.ch = 7'h46;
            14'd22:    r.ch = 7'h47;
            14'd170:   r.ch = 7'h48;
            14'd10:    r.ch = 7'h49;
            14'd149:   r.ch = 7'h4A;
            14'd25:    r.ch = 7'h4B;
            14'd154:   r.ch = 7'h4C;
            14'd5:     r.ch = 7'h4D;
            14'd6:     r.ch = 7'h4E;
            14'd21:    r.ch = 7'h4F;
            14'd150:   r.ch = 7'h50;
            14'd89:    r.ch = 7'h51;
            14'd38:    r.ch = 7'h52;
            14'd42:    r.ch = 7'h53;
            14'd1:     r.ch = 7'h54;
            14'd41:    r.ch = 7'h55;
            14'd169:   r.ch = 7'h56;
            14'd37:    r.ch = 7'h57;
            14'd105:   r.ch = 7'h58;
            14'd101:   r.ch = 7'h59;
            14'd90:    r.ch = 7'h5A;
            14'd341:   r.ch = 7'h30;
            14'd597:   r.ch = 7'h31;
            14'd661:   r.ch = 7'h32;
            14'd677:   r.ch = 7'h33;
            14'd681:   r.ch = 7'h34;
            14'd682:   r.ch = 7'h35;
            14'd426:   r.ch = 7'h36;
            14'd362:   r.ch = 7'h37;
            14'd346:   r.ch = 7'h38;
            14'd342:   r.ch = 7'h39;
            14'd2390:  r.ch = 7'h27;
            14'd2406:  r.ch = 7'h40;
            14'd1386:  r.ch = 7'h3A;
            14'd1445:  r.ch = 7'h2C;
            14'd10857: r.ch = 7'h24;
            14'd425:   r.ch = 7'h3D;
            14'd1637:  r.ch = 7'h21;
            14'd2457:  r.ch = 7'h2E;
            14'd2650:  r.ch = 7'h3F;
            14'd2470:  r.ch = 7'h22;
            default:   r.found = 1'b0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

/* design/mpsd_front.sv */
// Front end: accepts bytes, tracks the pending code and classifies the four symbols.
`timescale 1ns / 1ps
`default_nettype none

module mpsd_front
    import mpsd_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              data_valid,
    output logic                   data_stall,
    input  wire logic [BYTE_W-1:0] data_byte,
    input  wire logic              fifo_full,
    output logic                   push,
    output group_t                 push_data
);

    logic [CODE_W-1:0]  pending_code_reg, pending_code_next;
    logic [COUNT_W-1:0] symbol_count_reg, symbol_count_next;
    logic               overflow_seen_reg, overflow_seen_next;
    logic               accept;
    logic               any_event;

    assign data_stall = fifo_full;
    assign accept     = data_valid && !fifo_full;

    // Walk the four symbols, most significant pair first
    always_comb
    begin
        logic [CODE_W-1:0]  code;
        logic [COUNT_W-1:0] cnt;
        logic               ovf;
        sym_t               sym;
        code      = pending_code_reg;
        cnt       = symbol_count_reg;
        ovf       = overflow_seen_reg;
        any_event = 1'b0;
        push_data = '0;
        for (int i = 0; i < SYMS_PER_BYTE; i++)
        begin
            sym = sym_t'(data_byte[BYTE_W-1-2*i -: 2]);
            push_data.ev[i].kind = EV_NONE;
            push_data.ev[i].ovf  = 1'b0;
            push_data.ev[i].code = '0;
            unique case (sym)
                SYM_SPACE:
                begin
                    push_data.ev[i].kind = EV_SPACE;
                    push_data.ev[i].code = SPACE_CODE;
                    any_event = 1'b1;
                    code = '0;
                    cnt  = '0;
                    ovf  = 1'b0;
                end
                SYM_SEP:
                begin
                    if (cnt != '0 || ovf)
                    begin
                        push_data.ev[i].kind = EV_CHAR;
                        push_data.ev[i].ovf  = ovf;
                        push_data.ev[i].code = code;
                        any_event = 1'b1;
                    end
                    code = '0;
                    cnt  = '0;
                    ovf  = 1'b0;
                end
                default:
                begin
                    // dot or dash
                    if (cnt >= COUNT_W'(MAX_SYMBOLS))
                        ovf = 1'b1;
                    else
                        cnt = cnt + COUNT_W'(1);
                    code = {code[CODE_W-3:0], 2'(sym)};
                end
            endcase
        end
        pending_code_next  = code;
        symbol_count_next  = cnt;
        overflow_seen_next = ovf;
    end

    // Bytes that produce no character or space push nothing
    assign push = accept && any_event;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_code_reg  <= '0;
            symbol_count_reg  <= '0;
            overflow_seen_reg <= 1'b0;
        end
        else if (accept)
        begin
            pending_code_reg  <= pending_code_next;
            symbol_count_reg  <= symbol_count_next;
            overflow_seen_reg <= overflow_seen_next;
        end
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        symbol_count_reg <= COUNT_W'(MAX_SYMBOLS))
        else $error("symbol count beyond limit");

    a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
        overflow_seen_reg |-> symbol_count_reg == COUNT_W'(MAX_SYMBOLS))
        else $error("overflow flagged with short count");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !fifo_full)
        else $error("push into full queue");
`endif

endmodule

`default_nettype wire

/* design/mpsd_fifo.sv */
// Short queue of per-byte event groups between front and back.
`timescale 1ns / 1ps
`default_nettype none

module mpsd_fifo
    import mpsd_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  group_t    push_data,
    output logic      full,
    input  wire logic pop,
    output group_t    pop_data,
    output logic      nonempty
);

    group_t                mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_CNT_W-1:0] count_reg, count_next;

    assign full     = count_reg == FIFO_CNT_W'(FIFO_DEPTH);
    assign nonempty = count_reg != '0;
    assign pop_data = mem[rd_ptr_reg];

    // Occupancy update
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + FIFO_CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - FIFO_CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + FIFO_PTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + FIFO_PTR_W'(1);
            count_reg <= count_next;
        end
    end

`ifndef SYNTH
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push || pop)
        else $error("queue overrun");

    a_no_underrun: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> nonempty)
        else $error("queue underrun");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FIFO_CNT_W'(FIFO_DEPTH))
        else $error("queue count out of range");
`endif

endmodule

`default_nettype wire

/* design/mpsd_back.sv */
// Back end: emits one event per cycle unless the output is stalled, looks up the ROM and holds the output register.
`timescale 1ns / 1ps
`default_nettype none

module mpsd_back
    import mpsd_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               fifo_nonempty,
    input  group_t                  fifo_data,
    output logic                    pop,
    output logic                    result_valid,
    input  wire logic               result_stall,
    output logic [CHAR_W-1:0]       ascii_char,
    output logic [CODE_W-1:0]       code_value,
    output logic                    unknown_code,
    output logic                    overflow,
    output logic                    last_of_run
);

    group_t                   work_reg;
    logic [SYMS_PER_BYTE-1:0] mask_reg, mask_next;
    logic [SYMS_PER_BYTE-1:0] fifo_mask;
    logic [SYMS_PER_BYTE-1:0] sel_onehot;
    logic [SYMS_PER_BYTE-1:0] mask_after;
    event_t                   sel_ev;
    rom_result_t              rom;
    logic                     can_load;
    logic                     emit;

    logic                     result_valid_reg;
    logic [CHAR_W-1:0]        ascii_char_reg, ascii_char_next;
    logic [CODE_W-1:0]        code_value_reg;
    logic                     unknown_code_reg, unknown_code_next;
    logic                     overflow_reg, overflow_next;
    logic                     last_of_run_reg;

    // Slots of the incoming group that carry an event
    always_comb
    begin
        for (int i = 0; i < SYMS_PER_BYTE; i++)
            fifo_mask[i] = fifo_data.ev[i].kind != EV_NONE;
    end

    // Pick the earliest pending slot
    always_comb
    begin
        logic found;
        found      = 1'b0;
        sel_onehot = '0;
        sel_ev     = work_reg.ev[0];
        for (int i = 0; i < SYMS_PER_BYTE; i++)
        begin
            if (mask_reg[i] && !found)
            begin
                found         = 1'b1;
                sel_onehot[i] = 1'b1;
                sel_ev        = work_reg.ev[i];
            end
        end
    end

    assign mask_after = mask_reg & ~sel_onehot;
    assign can_load   = !result_valid_reg || !result_stall;
    assign emit       = (mask_reg != '0) && can_load;
    assign pop        = fifo_nonempty && ((mask_reg == '0) || (emit && mask_after == '0));
    assign rom        = rom_lookup(sel_ev.code);

    always_comb
    begin
        mask_next = mask_reg;
        if (pop)
            mask_next = fifo_mask;
        else if (emit)
            mask_next = mask_after;
    end

    // Result fields for the selected event
    always_comb
    begin
        ascii_char_next   = '0;
        unknown_code_next = 1'b0;
        overflow_next     = 1'b0;
        if (sel_ev.kind == EV_SPACE)
            ascii_char_next = SPACE_CHAR;
        else if (sel_ev.ovf)
            overflow_next = 1'b1;
        else
        begin
            ascii_char_next   = rom.ch;
            unknown_code_next = !rom.found;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            work_reg <= fifo_data;
        if (emit)
        begin
            ascii_char_reg   <= ascii_char_next;
            code_value_reg   <= sel_ev.code;
            unknown_code_reg <= unknown_code_next;
            overflow_reg     <= overflow_next;
            last_of_run_reg  <= mask_after == '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg         <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            mask_reg <= mask_next;
            if (emit)
                result_valid_reg <= 1'b1;
            else if (!result_stall)
                result_valid_reg <= 1'b0;
        end
    end

    assign result_valid = result_valid_reg;
    assign ascii_char   = ascii_char_reg;
    assign code_value   = code_value_reg;
    assign unknown_code = unknown_code_reg;
    assign overflow     = overflow_reg;
    assign last_of_run  = last_of_run_reg;

`ifndef SYNTH
    a_ovf_fields: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && overflow_reg |-> ascii_char_reg == '0 && !unknown_code_reg)
        else $error("overflow word carries a character");

    a_unk_fields: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && unknown_code_reg |-> ascii_char_reg == '0 && !overflow_reg)
        else $error("unknown word carries a character");

    a_pop_loads: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> mask_reg != '0)
        else $error("popped group with no events");

    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && result_stall |=> result_valid_reg)
        else $error("stalled word dropped");
`endif

endmodule

`default_nettype wire

/* design/morse_pair_stream_decoder.sv */
// The first result word of a byte passes the group queue, work register and output register.
// The back end gives one result word per cycle while result_stall is low; a byte that
// produces no character or space is not queued.
// A 2-entry group queue lets the front take bytes while the back still drains.
// Reset (rst_n, async, active low) clears pending code, count, queue and valid.
`timescale 1ns / 1ps
`default_nettype none

module morse_pair_stream_decoder
    import mpsd_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              data_valid,
    output logic                   data_stall,
    input  wire logic [BYTE_W-1:0] data_byte,
    output logic                   result_valid,
    input  wire logic              result_stall,
    output logic [CHAR_W-1:0]      ascii_char,
    output logic [CODE_W-1:0]      code_value,
    output logic                   unknown_code,
    output logic                   overflow,
    output logic                   last_of_run
);

    logic   push;
    group_t push_data;
    logic   fifo_full;
    logic   pop;
    group_t pop_data;
    logic   fifo_nonempty;

    // Symbol classification and pending code
    mpsd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .data_valid (data_valid),
        .data_stall (data_stall),
        .data_byte  (data_byte),
        .fifo_full  (fifo_full),
        .push       (push),
        .push_data  (push_data)
    );

    // Group queue
    mpsd_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (fifo_full),
        .pop       (pop),
        .pop_data  (pop_data),
        .nonempty  (fifo_nonempty)
    );

    // Character lookup and output
    mpsd_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .fifo_nonempty (fifo_nonempty),
        .fifo_data     (pop_data),
        .pop           (pop),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .ascii_char    (ascii_char),
        .code_value    (code_value),
        .unknown_code  (unknown_code),
        .overflow      (overflow),
        .last_of_run   (last_of_run)
    );

endmodule

`default_nettype wire
